// ===== rtl/core/float_hypotenuse_unit_macros.svh =====
// Assertion helpers; expect i_clk and i_rst_n in scope.
`ifndef FLOAT_HYPOTENUSE_UNIT_MACROS_SVH
`define FLOAT_HYPOTENUSE_UNIT_MACROS_SVH

// same-cycle implication
`define FHU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FHU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fhu_pkg.sv =====
package fhu_pkg;

    localparam logic [30:0] EXP_ALL  = 31'h7f800000;
    localparam logic [31:0] INF_BITS = 32'h7f800000;
    localparam logic [31:0] QNAN_BIT = 32'h00400000;
    localparam int          SQ_STEPS = 55;

    typedef struct packed {
        logic        spec;
        logic [31:0] val;
    } t_side;

    typedef struct packed {
        logic [53:0]        m;
        logic signed [11:0] e;
        t_side              side;
    } t_rad;

    typedef struct packed {
        logic [54:0]        q;
        logic               rnz;
        logic signed [11:0] e;
        t_side              side;
    } t_root;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                cnt = 5'(23 - i);
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/fhu_if.sv =====
interface fhu_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;
    logic [31:0] y_bits;

    modport source (output valid, output x_bits, output y_bits, input ready);
    modport sink   (input valid, input x_bits, input y_bits, output ready);
endinterface

interface fhu_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] hyp_bits;

    modport source (output valid, output hyp_bits, input ready);
    modport sink   (input valid, input hyp_bits, output ready);
endinterface

// ===== rtl/core/fhu_sumsq.sv =====
module fhu_sumsq import fhu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_valid,
    output t_rad        o_rad
);

    function automatic logic [33:0] unpack(input logic [30:0] a);
        logic [23:0]       m;
        logic [4:0]        lz;
        logic signed [9:0] e;
        if (a[30:23] == 8'd0) begin
            m = {1'b0, a[22:0]};
            e = -10'sd149;
        end else begin
            m = {1'b1, a[22:0]};
            e = $signed({2'b00, a[30:23]}) - 10'sd150;
        end
        lz = lzc24(m);
        m  = m << lz;
        e  = e - $signed({5'b00000, lz});
        return {m, e};
    endfunction

    // stage 1: classify, unpack
    logic [30:0] ax, ay;
    logic        x_inf, y_inf, x_nan, y_nan;
    t_side       n1_side;
    logic [33:0] ux, uy;

    assign ax    = i_x[30:0];
    assign ay    = i_y[30:0];
    assign x_inf = (ax == EXP_ALL);
    assign y_inf = (ay == EXP_ALL);
    assign x_nan = (ax[30:23] == 8'hff) && !x_inf;
    assign y_nan = (ay[30:23] == 8'hff) && !y_inf;
    assign ux    = unpack(ax);
    assign uy    = unpack(ay);

    always_comb begin
        n1_side.spec = 1'b1;
        n1_side.val  = INF_BITS;
        if (x_inf || y_inf) begin
            n1_side.val = INF_BITS;
        end else if (x_nan) begin
            n1_side.val = i_x | QNAN_BIT;
        end else if (y_nan) begin
            n1_side.val = i_y | QNAN_BIT;
        end else if (ax == 31'd0) begin
            n1_side.val = {1'b0, ay};
        end else if (ay == 31'd0) begin
            n1_side.val = {1'b0, ax};
        end else begin
            n1_side.spec = 1'b0;
        end
    end

    logic [5:0]         r_v;
    t_side              r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [23:0]        r1_ma, r1_mb;
    logic signed [9:0]  r1_ea, r1_eb;
    logic [47:0]        r2_pa, r2_pb;
    logic signed [11:0] r2_ea, r2_eb;
    logic [47:0]        r3_p1, r3_p2;
    logic signed [11:0] r3_e1;
    logic [5:0]         r3_d;
    logic [56:0]        r4_a, r4_b;
    logic signed [11:0] r4_e1;
    logic [57:0]        r5_s;
    logic signed [11:0] r5_e1;
    t_rad               r6_rad;

    // stage 3: normalize squares, order
    logic [47:0]        pan, pbn;
    logic signed [11:0] ean, ebn, e1, e2, d;
    logic               a_big;

    always_comb begin
        pan   = r2_pa[47] ? r2_pa : (r2_pa << 1);
        ean   = r2_pa[47] ? r2_ea : (r2_ea - 12'sd1);
        pbn   = r2_pb[47] ? r2_pb : (r2_pb << 1);
        ebn   = r2_pb[47] ? r2_eb : (r2_eb - 12'sd1);
        a_big = (ean > ebn) || ((ean == ebn) && (pan >= pbn));
        e1    = a_big ? ean : ebn;
        e2    = a_big ? ebn : ean;
        d     = e1 - e2;
    end

    // stage 4: align with sticky
    logic [56:0] bfull, bsh, bmask;
    logic        bst;

    always_comb begin
        bfull = {r3_p2, 9'd0};
        bsh   = bfull >> r3_d;
        bmask = (57'd1 << r3_d) - 57'd1;
        bst   = |(bfull & bmask);
    end

    // stage 6: round to 53 bits, make exponent even
    logic [52:0]        keep, m53;
    logic               g, st, inc;
    logic [53:0]        mr;
    logic signed [11:0] el, el2;

    always_comb begin
        if (r5_s[57]) begin
            keep = r5_s[57:5];
            g    = r5_s[4];
            st   = |r5_s[3:0];
            el   = r5_e1 - 12'sd4;
        end else begin
            keep = r5_s[56:4];
            g    = r5_s[3];
            st   = |r5_s[2:0];
            el   = r5_e1 - 12'sd5;
        end
        inc = g & (st | keep[0]);
        mr  = {1'b0, keep} + {53'd0, inc};
        if (mr[53]) begin
            m53 = mr[53:1];
            el2 = el + 12'sd1;
        end else begin
            m53 = mr[52:0];
            el2 = el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
            r1_ma   <= ux[33:10];
            r1_ea   <= $signed(ux[9:0]);
            r1_mb   <= uy[33:10];
            r1_eb   <= $signed(uy[9:0]);

            r2_side <= r1_side;
            r2_pa   <= 48'(r1_ma) * 48'(r1_ma);
            r2_pb   <= 48'(r1_mb) * 48'(r1_mb);
            r2_ea   <= $signed({r1_ea[9], r1_ea, 1'b0});
            r2_eb   <= $signed({r1_eb[9], r1_eb, 1'b0});

            r3_side <= r2_side;
            r3_p1   <= a_big ? pan : pbn;
            r3_p2   <= a_big ? pbn : pan;
            r3_e1   <= e1;
            r3_d    <= (d > 12'sd57) ? 6'd57 : d[5:0];

            r4_side <= r3_side;
            r4_a    <= {r3_p1, 9'd0};
            r4_b    <= bsh | {56'd0, bst};
            r4_e1   <= r3_e1;

            r5_side <= r4_side;
            r5_s    <= {1'b0, r4_a} + {1'b0, r4_b};
            r5_e1   <= r4_e1;

            r6_rad.side <= r5_side;
            r6_rad.m    <= el2[0] ? {m53, 1'b0} : {1'b0, m53};
            r6_rad.e    <= el2[0] ? (el2 - 12'sd1) : el2;
        end
    end

    assign o_valid = r_v[5];
    assign o_rad   = r6_rad;

endmodule

// ===== rtl/core/fhu_sqrt.sv =====
module fhu_sqrt import fhu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_rad  i_rad,
    output logic  o_valid,
    output t_root o_root
);

    logic [SQ_STEPS-1:0] r_v;
    logic [54:0]         r_q [SQ_STEPS];
    logic [57:0]         r_r [SQ_STEPS];
    logic [53:0]         r_m [SQ_STEPS];
    logic signed [11:0]  r_e [SQ_STEPS];
    t_side               r_side [SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQ_STEPS-2:0], i_valid};
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        logic [54:0]        q_in;
        logic [57:0]        r_in, r_sh, t;
        logic [53:0]        m_in;
        logic signed [11:0] e_in;
        t_side              s_in;
        logic               take;

        if (j == 0) begin : g_first
            assign q_in = '0;
            assign r_in = '0;
            assign m_in = i_rad.m;
            assign e_in = i_rad.e;
            assign s_in = i_rad.side;
        end else begin : g_next
            assign q_in = r_q[j-1];
            assign r_in = r_r[j-1];
            assign m_in = r_m[j-1];
            assign e_in = r_e[j-1];
            assign s_in = r_side[j-1];
        end

        assign r_sh = {r_in[55:0], m_in[53:52]};
        assign t    = {1'b0, q_in, 2'b01};
        assign take = (r_sh >= t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]    <= {q_in[53:0], take};
                r_r[j]    <= take ? (r_sh - t) : r_sh;
                r_m[j]    <= {m_in[51:0], 2'b00};
                r_e[j]    <= e_in;
                r_side[j] <= s_in;
            end
        end
    end

    assign o_valid     = r_v[SQ_STEPS-1];
    assign o_root.q    = r_q[SQ_STEPS-1];
    assign o_root.rnz  = (r_r[SQ_STEPS-1] != 58'd0);
    assign o_root.e    = r_e[SQ_STEPS-1];
    assign o_root.side = r_side[SQ_STEPS-1];

endmodule

// ===== rtl/core/fhu_pack.sv =====
module fhu_pack import fhu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_root       i_root,
    output logic        o_valid,
    output logic [31:0] o_bits
);

    logic [2:0]         r_v;
    t_side              r1_side, r2_side;
    logic [52:0]        r1_mant;
    logic signed [11:0] r1_e2;
    logic [23:0]        r2_q;
    logic               r2_g, r2_st, r2_norm, r2_ovf;
    logic [7:0]         r2_exp;
    logic [31:0]        r3_bits;

    // P1: round root to 53 bits
    logic [52:0]        mant;
    logic [53:0]        mr;
    logic               inc1;
    logic signed [11:0] e2;

    always_comb begin
        mant = i_root.q[54:2];
        inc1 = i_root.q[1] & (i_root.q[0] | i_root.rnz | mant[0]);
        mr   = {1'b0, mant} + {53'd0, inc1};
        e2   = (i_root.e >>> 1) - 12'sd26;
    end

    // P2: shift to single quantum
    logic signed [11:0] un, shs;
    logic               norm, ovf;
    logic [5:0]         sh, shg;
    logic [63:0]        mx, qx;

    always_comb begin
        un   = r1_e2 + 12'sd52;
        ovf  = (un > 12'sd127);
        norm = (un >= -12'sd126);
        shs  = -12'sd149 - r1_e2;
        if (norm) begin
            sh = 6'd29;
        end else if (shs > 12'sd63) begin
            sh = 6'd63;
        end else begin
            sh = shs[5:0];
        end
        shg = sh - 6'd1;
        mx  = {11'd0, r1_mant};
        qx  = mx >> sh;
    end

    // P3: round and pack
    logic [24:0] qq;
    logic [31:0] bits;

    always_comb begin
        qq = {1'b0, r2_q} + {24'd0, r2_g & (r2_st | r2_q[0])};
        if (r2_norm) begin
            bits = {1'b0, r2_exp, 23'd0} + {7'd0, qq};
        end else begin
            bits = {7'd0, qq};
        end
        if (r2_ovf || bits >= INF_BITS) begin
            bits = INF_BITS;
        end
        if (r2_side.spec) begin
            bits = r2_side.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_root.side;
            r1_mant <= mr[53] ? mr[53:1] : mr[52:0];
            r1_e2   <= mr[53] ? (e2 + 12'sd1) : e2;

            r2_side <= r1_side;
            r2_q    <= qx[23:0];
            r2_g    <= mx[shg];
            r2_st   <= |(mx & ((64'd1 << shg) - 64'd1));
            r2_norm <= norm;
            r2_ovf  <= ovf;
            r2_exp  <= 8'(un + 12'sd126);

            r3_bits <= bits;
        end
    end

    assign o_valid = r_v[2];
    assign o_bits  = r3_bits;

endmodule

// ===== rtl/core/float_hypotenuse_unit.sv =====
// Single-precision hypot: each request carries two IEEE-754 single patterns and returns
// sqrt(x*x+y*y) as a single pattern. One request is taken per clock while the skid
// entry is empty; a result passes in order through squaring and double-precision
// summing, one root bit per stage of a 55-stage restoring square root, rounding and
// packing, and the output register. A two-entry output stage (result plus skid) lets
// the pipeline keep moving while one result waits; the pipeline halts only when both
// entries are full. Infinite operands give +infinity, NaN operands are returned
// quieted, and a zero operand returns the other operand's magnitude.
`include "float_hypotenuse_unit_macros.svh"

module float_hypotenuse_unit import fhu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fhu_req_if.sink   i_op,
    fhu_res_if.source o_res
);

    logic        en;
    logic        sq_valid, rt_valid, pk_valid;
    t_rad        sq_rad;
    t_root       rt_root;
    logic [31:0] pk_bits;

    logic        r_ov, r_sv;
    logic [31:0] r_od, r_sd;
    logic        take;

    assign en         = !r_sv;
    assign i_op.ready = en;
    assign take       = r_ov && o_res.ready;

    fhu_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_op.valid),
        .i_x     (i_op.x_bits),
        .i_y     (i_op.y_bits),
        .o_valid (sq_valid),
        .o_rad   (sq_rad)
    );

    fhu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_rad   (sq_rad),
        .o_valid (rt_valid),
        .o_root  (rt_root)
    );

    fhu_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_valid),
        .i_root  (rt_root),
        .o_valid (pk_valid),
        .o_bits  (pk_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (pk_valid) begin
            if (r_ov && !take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
            end
        end else if (pk_valid) begin
            if (r_ov && !take) begin
                r_sd <= pk_bits;
            end else begin
                r_od <= pk_bits;
            end
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.hyp_bits = r_od;

    `FHU_ASSERT_NOW(a_skid_needs_out, r_sv, r_ov, "skid holds a result with output empty")
    `FHU_ASSERT_NEXT(a_skid_fill, r_ov && !o_res.ready && !r_sv && pk_valid, r_sv && r_ov, "result lost on stall")
    `FHU_ASSERT_NEXT(a_skid_drain, r_sv && o_res.ready, r_ov && !r_sv, "skid did not drain")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import fhu_pkg::*;

    localparam int N_RANDOM   = 1330;
    localparam int WDOG_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 100;

    typedef enum int {K_RAND, K_CLOSE, K_SUBN, K_SPEC, K_HUGE, K_TINY} t_pair_kind;

    typedef struct {
        logic        fixed;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] hyp;
    } t_vec;

    logic i_clk;
    logic i_rst_n;

    fhu_req_if op_if();
    fhu_res_if res_if();

    float_hypotenuse_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if.sink),
        .o_res   (res_if.source)
    );

    logic [31:0] hyp_expected[$];
    int          err_count;
    int          idle_cycles;
    bit          burst_mode;
    bit          hold_req;
    bit          res_took;

    t_vec directed[] = '{
        '{1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
        '{1'b1, 32'h80000000, 32'hc0400000, 32'h40400000},
        '{1'b1, 32'hc0800000, 32'h80000000, 32'h40800000},
        '{1'b1, 32'h7f800000, 32'h7fc00001, 32'h7f800000},
        '{1'b1, 32'hff800000, 32'h00000001, 32'h7f800000},
        '{1'b1, 32'h7fa00001, 32'hff800000, 32'h7f800000},
        '{1'b1, 32'h7f800001, 32'h00000000, 32'h7fc00001},
        '{1'b1, 32'h00000000, 32'hffa00000, 32'hffe00000},
        '{1'b1, 32'h3f800000, 32'h7fc12345, 32'h7fc12345},
        '{1'b1, 32'h40400000, 32'h40800000, 32'h40a00000},
        '{1'b1, 32'h7f7fffff, 32'h7f7fffff, 32'h7f800000},
        '{1'b1, 32'hffffffff, 32'h7fffffff, 32'hffffffff},
        '{1'b0, 32'h00000001, 32'h00000001, 32'h0},
        '{1'b0, 32'h00000001, 32'h80000001, 32'h0},
        '{1'b0, 32'h007fffff, 32'h007fffff, 32'h0},
        '{1'b0, 32'h00800000, 32'h80800000, 32'h0},
        '{1'b0, 32'h7f7fffff, 32'h00000001, 32'h0},
        '{1'b0, 32'h5f000000, 32'h5f000000, 32'h0},
        '{1'b0, 32'h1f800000, 32'h1f800000, 32'h0},
        '{1'b0, 32'h3f800000, 32'h3f800000, 32'h0},
        '{1'b0, 32'hbf800001, 32'h33800000, 32'h0},
        '{1'b0, 32'h20000000, 32'h00000003, 32'h0}
    };

    function automatic real pow2(int k);
        logic [10:0] ex;
        ex = 11'(1023 + k);
        return $bitstoreal({1'b0, ex, 52'd0});
    endfunction

    function automatic real single_to_real(logic [30:0] v);
        longint frac;
        frac = longint'(v[22:0]);
        if (v[30:23] == 8'd0) begin
            return real'(frac) * pow2(-149);
        end
        return real'(frac + 64'h800000) * pow2(int'(v[30:23]) - 150);
    endfunction

    function automatic logic [31:0] pack_single(logic [63:0] mant, int e2);
        int          un;
        int          sh;
        logic [63:0] qq;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        un = e2 + 52;
        if (un > 127) begin
            return INF_BITS;
        end
        sh = (un >= -126) ? 29 : (-149 - e2);
        if (sh > 63) begin
            sh = 63;
        end
        qq   = mant >> sh;
        rem  = mant & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && qq[0])) begin
            qq++;
        end
        if (un >= -126) begin
            bits = (64'(un + 126) << 23) + qq;
        end else begin
            bits = qq;
        end
        if (bits >= 64'h7f800000) begin
            bits = 64'h7f800000;
        end
        return bits[31:0];
    endfunction

    function automatic logic [31:0] hypot_of(logic [31:0] x, logic [31:0] y);
        logic [30:0] ax;
        logic [30:0] ay;
        real         s;
        logic [63:0] sb;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] pr;
        logic [63:0] mant;
        int          ef;
        int          e;
        int          e2;
        ax = x[30:0];
        ay = y[30:0];
        if ({1'b0, ax} == INF_BITS || {1'b0, ay} == INF_BITS) begin
            return INF_BITS;
        end
        if (ax[30:23] == 8'hff) begin
            return x | QNAN_BIT;
        end
        if (ay[30:23] == 8'hff) begin
            return y | QNAN_BIT;
        end
        if (ax == 31'd0) begin
            return {1'b0, ay};
        end
        if (ay == 31'd0) begin
            return {1'b0, ax};
        end
        s  = single_to_real(ax) * single_to_real(ax) + single_to_real(ay) * single_to_real(ay);
        sb = $realtobits(s);
        ef = int'(sb[62:52]);
        m  = {12'd1, sb[51:0]};
        e  = ef - 1075;
        if (e % 2 != 0) begin
            m = m << 1;
            e = e - 1;
        end
        q = 64'd0;
        r = 64'd0;
        for (int i = 54; i >= 0; i--) begin
            pr = (i >= 28) ? ((m >> (2 * (i - 28))) & 64'd3) : 64'd0;
            r  = (r << 2) | pr;
            t  = (q << 2) | 64'd1;
            if (r >= t) begin
                r = r - t;
                q = (q << 1) | 64'd1;
            end else begin
                q = q << 1;
            end
        end
        mant = q >> 2;
        if (q[1] && (q[0] || r != 64'd0 || mant[0])) begin
            mant++;
        end
        e2 = e / 2 - 26;
        if (mant == 64'h0020000000000000) begin
            mant = mant >> 1;
            e2++;
        end
        return pack_single(mant, e2);
    endfunction

    function automatic logic [31:0] special_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v[30:0] = 31'd0;
            1: v[30:0] = INF_BITS[30:0];
            default: begin
                v[30:23] = 8'hff;
                if (v[22:0] == 23'd0) begin
                    v[0] = 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    task automatic make_pair(output logic [31:0] x, output logic [31:0] y);
        t_pair_kind kind;
        int         ex;
        kind = t_pair_kind'($urandom_range(0, 5));
        x = $urandom;
        y = $urandom;
        case (kind)
            K_CLOSE: begin
                ex = $urandom_range(4, 250);
                x[30:23] = 8'(ex);
                y[30:23] = 8'(ex + $urandom_range(0, 6) - 3);
            end
            K_SUBN: begin
                x[30:23] = 8'd0;
                y[30:23] = 8'($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
            end
            K_SPEC: begin
                if ($urandom_range(0, 1)) begin
                    x = special_operand();
                end else begin
                    y = special_operand();
                end
            end
            K_HUGE: begin
                x[30:23] = 8'($urandom_range(190, 254));
                y[30:23] = 8'($urandom_range(180, 254));
            end
            K_TINY: begin
                x[30:23] = 8'($urandom_range(0, 70));
                y[30:23] = 8'($urandom_range(0, 70));
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic send_request(logic [31:0] x, logic [31:0] y);
        int  gap;
        bit  taken;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_if.valid  <= 1'b1;
        op_if.x_bits <= x;
        op_if.y_bits <= y;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (op_if.ready) begin
                taken = 1'b1;
                hyp_expected.push_back(hypot_of(x, y));
            end
            @(posedge i_clk);
        end
    endtask

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_took <= 1'b1;
            if (hyp_expected.size() == 0) begin
                report_mismatch("unexpected result", res_if.hyp_bits, 32'h0);
            end else begin
                if (res_if.hyp_bits !== hyp_expected[0]) begin
                    report_mismatch("hyp_bits", res_if.hyp_bits, hyp_expected[0]);
                end
                void'(hyp_expected.pop_front());
            end
        end else begin
            res_took <= 1'b0;
        end
    end

    initial begin
        int rx_wait;
        int hold_cnt;
        bit hold_done;
        rx_wait   = 0;
        hold_cnt  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_LEN;
            end
            if (res_took) begin
                rx_wait = burst_mode ? 0 : $urandom_range(0, 15);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                res_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] x;
        logic [31:0] y;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        op_if.valid  = 1'b0;
        op_if.x_bits = 32'd0;
        op_if.y_bits = 32'd0;
        res_if.ready = 1'b0;
        err_count    = 0;
        idle_cycles  = 0;
        burst_mode   = 1'b0;
        hold_req     = 1'b0;
        res_took     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_request(directed[k].x, directed[k].y);
            if (directed[k].fixed && hypot_of(directed[k].x, directed[k].y) !== directed[k].hyp) begin
                report_mismatch("directed row", hypot_of(directed[k].x, directed[k].y),
                                directed[k].hyp);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            burst_mode <= (n >= 700 && n < 900);
            if (n == 400) begin
                hold_req <= 1'b1;
            end
            make_pair(x, y);
            send_request(x, y);
        end
        op_if.valid <= 1'b0;

        while (hyp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
